### hdl/blendshape_vertex_combiner_macros.svh
// assertion macros for the blendshape combiner checker
`ifndef BLENDSHAPE_VERTEX_COMBINER_MACROS_SVH
`define BLENDSHAPE_VERTEX_COMBINER_MACROS_SVH

// same-cycle implication, held off during reset
`define BSVC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define BSVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bsvc_pkg.sv
`timescale 1ns / 1ps

package bsvc_pkg;

	localparam int FUNC_W   = 2;
	localparam int SHAPE_W  = 6;
	localparam int VERT_W   = 12;
	localparam int POS_W    = 24;
	localparam int WEIGHT_W = 16;

	// weight fraction bits, also the shift from the accumulator back to Q12.12
	localparam int FRAC_SHIFT = 14;

	localparam int DEF_NUM_SHAPES   = 39;
	localparam int DEF_NUM_VERTICES = 4096;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_NEUTRAL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_TARGET  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_SET_WEIGHT   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE      = 2'd3;

	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic [FUNC_W-1:0]          func;
		logic [SHAPE_W-1:0]         shape_index;
		logic [VERT_W-1:0]          vertex_index;
		logic signed [POS_W-1:0]    in_x;
		logic signed [POS_W-1:0]    in_y;
		logic signed [POS_W-1:0]    in_z;
		logic signed [WEIGHT_W-1:0] weight;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    saturated;
	} result_t;

	typedef struct packed {
		logic               load;
		logic               wr_neutral;
		logic               wr_weight;
		logic               wr_delta;
		logic               mac_issue;
		logic               acc_init;
		logic               finish;
		logic [SHAPE_W-1:0] cnt;
	} ctl_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              vert_ok;
		logic              shape_ok;
	} dp_status_t;

endpackage

### hdl/bsvc_ram.sv
`timescale 1ns / 1ps

module bsvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/bsvc_controller.sv
`timescale 1ns / 1ps

module bsvc_controller import bsvc_pkg::*; #(
	parameter int NUM_SHAPES = DEF_NUM_SHAPES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctl_cmd_t   cmd,
	output logic       busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_DELTA  = 3'd2;
	localparam logic [2:0] ST_MAC    = 3'd3;
	localparam logic [2:0] ST_DRAIN1 = 3'd4;
	localparam logic [2:0] ST_DRAIN2 = 3'd5;
	localparam logic [2:0] ST_ROUND  = 3'd6;

	localparam logic [SHAPE_W-1:0] LAST_SHAPE = SHAPE_W'(NUM_SHAPES - 1);

	logic [2:0]         state_q;
	logic [2:0]         state_d;
	logic [SHAPE_W-1:0] cnt_q;
	logic [SHAPE_W-1:0] cnt_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (status.func)
					FUNC_LOAD_NEUTRAL: begin
						cmd.wr_neutral = status.vert_ok;
					end
					FUNC_SET_WEIGHT: begin
						cmd.wr_weight = status.shape_ok;
					end
					FUNC_LOAD_TARGET: begin
						// neutral read is issued this cycle, data lands next
						if (status.vert_ok && status.shape_ok) begin
							state_d = ST_DELTA;
						end
					end
					FUNC_COMPUTE: begin
						cnt_d = '0;
						if (status.vert_ok) begin
							state_d = ST_MAC;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DELTA: begin
				cmd.wr_delta = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.acc_init  = (cnt_q == '0);
				if (cnt_q == LAST_SHAPE) begin
					state_d = ST_DRAIN1;
				end else begin
					cnt_d = cnt_q + SHAPE_W'(1);
				end
			end
			ST_DRAIN1: begin
				state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### hdl/bsvc_datapath.sv
`timescale 1ns / 1ps

module bsvc_datapath import bsvc_pkg::*; #(
	parameter int NUM_SHAPES   = DEF_NUM_SHAPES,
	parameter int NUM_VERTICES = DEF_NUM_VERTICES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	output result_t    result,
	output logic       done
);

	localparam int VW     = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int SW     = (NUM_SHAPES > 1) ? $clog2(NUM_SHAPES) : 1;
	localparam int DDEPTH = NUM_SHAPES * (1 << VW);
	localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
	localparam int PROD_W = POS_W + WEIGHT_W;
	localparam int ACC_W  = PROD_W + $clog2(NUM_SHAPES + 1) + 1;
	localparam int RW     = ACC_W + 1 - FRAC_SHIFT;
	localparam int PACK_W = 3 * POS_W;

	localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W + 1)'(1) << (FRAC_SHIFT - 1);

	item_t item_q;

	logic [VW-1:0]     vaddr;
	logic [SW-1:0]     saddr;
	logic [SW-1:0]     caddr;
	logic [PACK_W-1:0] n_rd;
	logic [PACK_W-1:0] d_rd;
	logic [WEIGHT_W-1:0] w_rd;
	logic [PACK_W-1:0] delta_pack;

	logic signed [POS_W-1:0]  pos_in [3];
	logic signed [POS_W-1:0]  nv     [3];
	logic [POS_W:0]           dif    [3];

	logic                     rd_s1;
	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_s2 [3];
	logic signed [ACC_W-1:0]  acc_q   [3];

	logic signed [ACC_W:0]    rsum [3];
	logic [RW-1:0]            rq   [3];
	logic [POS_W-1:0]         rpos [3];
	logic [2:0]               rsat;

	result_t result_q;
	logic    done_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	assign vaddr = VW'(item_q.vertex_index);
	assign saddr = SW'(item_q.shape_index);
	assign caddr = SW'(cmd.cnt);

	assign status.func     = item_q.func;
	assign status.vert_ok  = (32'(item_q.vertex_index) < 32'(NUM_VERTICES));
	assign status.shape_ok = (32'(item_q.shape_index) < 32'(NUM_SHAPES));

	assign pos_in[0] = item_q.in_x;
	assign pos_in[1] = item_q.in_y;
	assign pos_in[2] = item_q.in_z;

	bsvc_ram #(
		.WIDTH(PACK_W),
		.DEPTH(NUM_VERTICES)
	) u_neutral_ram (
		.clk  (clk),
		.we   (cmd.wr_neutral),
		.waddr(vaddr),
		.wdata({item_q.in_z, item_q.in_y, item_q.in_x}),
		.raddr(vaddr),
		.rdata(n_rd)
	);

	bsvc_ram #(
		.WIDTH(WEIGHT_W),
		.DEPTH(NUM_SHAPES)
	) u_weight_ram (
		.clk  (clk),
		.we   (cmd.wr_weight),
		.waddr(saddr),
		.wdata(item_q.weight),
		.raddr(caddr),
		.rdata(w_rd)
	);

	bsvc_ram #(
		.WIDTH(PACK_W),
		.DEPTH(DDEPTH)
	) u_delta_ram (
		.clk  (clk),
		.we   (cmd.wr_delta),
		.waddr(DAW'({saddr, vaddr})),
		.wdata(delta_pack),
		.raddr(DAW'({caddr, vaddr})),
		.rdata(d_rd)
	);

	// target minus neutral, clamped by looking at the two top bits
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			nv[a]  = $signed(n_rd[a*POS_W +: POS_W]);
			dif[a] = {pos_in[a][POS_W-1], pos_in[a]} - {nv[a][POS_W-1], nv[a]};
			if (!dif[a][POS_W] && dif[a][POS_W-1]) begin
				delta_pack[a*POS_W +: POS_W] = POS_MAX;
			end else if (dif[a][POS_W] && !dif[a][POS_W-1]) begin
				delta_pack[a*POS_W +: POS_W] = POS_MIN;
			end else begin
				delta_pack[a*POS_W +: POS_W] = dif[a][POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			rd_s1 <= cmd.mac_issue;
			v_s2  <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (rd_s1) begin
				prod_s2[a] <= $signed(d_rd[a*POS_W +: POS_W]) * $signed(w_rd);
			end
			if (cmd.acc_init) begin
				acc_q[a] <= ACC_W'(nv[a]) <<< FRAC_SHIFT;
			end else if (v_s2) begin
				acc_q[a] <= acc_q[a] + ACC_W'(prod_s2[a]);
			end
		end
	end

	// round half up, then clamp to Q12.12
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rsum[a] = (ACC_W + 1)'(acc_q[a]) + RND_BIAS;
			rq[a]   = rsum[a][ACC_W:FRAC_SHIFT];
			rsat[a] = 1'b0;
			rpos[a] = rq[a][POS_W-1:0];
			if (rq[a][RW-1] && !(&rq[a][RW-1:POS_W-1])) begin
				rpos[a] = POS_MIN;
				rsat[a] = 1'b1;
			end else if (!rq[a][RW-1] && (|rq[a][RW-1:POS_W-1])) begin
				rpos[a] = POS_MAX;
				rsat[a] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.pos_x     <= rpos[0];
			result_q.pos_y     <= rpos[1];
			result_q.pos_z     <= rpos[2];
			result_q.saturated <= |rsat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

### hdl/blendshape_vertex_combiner.sv
`timescale 1ns / 1ps

// blendshape vertex combiner
// input: a word on item is taken at a rising edge with start high and busy low.
// func picks the job: load a neutral vertex, load a shape target (stored as a
// delta from the neutral, clamped to 24 bits), set a shape weight, or compute.
// output: a compute word gives one result word on result, shown for exactly
// one cycle with done high; the receiver cannot stall, so it must take it then.
// loads, weight sets and out-of-range indexes give no result.
// busy: neutral load and weight set hold busy through the decode state only,
// a target load also through the delta write state. a compute also holds it
// through one pass of the per-axis multiply-accumulates over the shape stores,
// then the read, product and rounding stages; done rises in the same cycle
// that busy falls, and a new word can be taken then, but not while busy is high.
// reset clears the controller and done; the vertex, delta and weight stores
// are not cleared and must be written before they are read.

module blendshape_vertex_combiner import bsvc_pkg::*; #(
	parameter int NUM_SHAPES   = DEF_NUM_SHAPES,
	parameter int NUM_VERTICES = DEF_NUM_VERTICES
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	bsvc_controller #(
		.NUM_SHAPES(NUM_SHAPES)
	) u_controller (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	bsvc_datapath #(
		.NUM_SHAPES  (NUM_SHAPES),
		.NUM_VERTICES(NUM_VERTICES)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.status(status),
		.result(result),
		.done  (done)
	);

endmodule

### hdl/bsvc_checker.sv
`timescale 1ns / 1ps

`include "blendshape_vertex_combiner_macros.svh"

module bsvc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// results come out after the work is over
	`BSVC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "done while busy")

	`BSVC_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy), "done without work")

	`BSVC_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "done longer than one cycle")

	`BSVC_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted word not busy")

endmodule

bind blendshape_vertex_combiner bsvc_checker u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
